/* sv/wsat_pkg.sv */
// wsat_pkg: shared types and constants for the station association table
// no dependencies
package wsat_pkg;

    localparam int unsigned MAC_W = 48;
    localparam int unsigned TIME_W = 40;
    localparam int unsigned CFG_W = 32;
    localparam int unsigned CNT_W = 7;
    localparam int unsigned ROLE_W = 2;
    localparam int unsigned TABLE_ENTRIES_DEF = 64;
    localparam int unsigned ENTRY_W = MAC_W + MAC_W + ROLE_W + 3 * TIME_W;

    localparam logic [CFG_W-1:0] EXPIRY_RST = 32'd300000;
    localparam logic [CFG_W-1:0] DUPE_RST = 32'd60000;
    localparam logic [CFG_W-1:0] AP_HOLD_RST = 32'd60000;
    localparam logic [CFG_W-1:0] RX_HOLD_RST = 32'd60000;

    localparam logic [1:0] REG_EXPIRY = 2'd0;
    localparam logic [1:0] REG_DUPE = 2'd1;
    localparam logic [1:0] REG_AP_HOLD = 2'd2;
    localparam logic [1:0] REG_RX_HOLD = 2'd3;

    localparam logic [1:0] REQ_FRAME = 2'd0;
    localparam logic [1:0] REQ_SWEEP = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;

    localparam int unsigned ROLE_AP_BIT = 0;
    localparam int unsigned ROLE_IBSS_BIT = 1;

    typedef struct packed {
        logic [MAC_W-1:0]  key;
        logic [MAC_W-1:0]  bssid;
        logic [ROLE_W-1:0] role;
        logic [TIME_W-1:0] upd;
        logic [TIME_W-1:0] dup;
        logic [TIME_W-1:0] txt;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WAIT,
        ST_APPLY,
        ST_COUNT,
        ST_OUT
    } state_t;

endpackage

/* sv/wifi_station_association_table.sv */
// station association table: one scan of the entry memory per station update, sweep or lookup,
// then a recount pass; a passing frame is scanned once for the transmitter and once for the receiver
// throughput: one word at a time; the next is accepted only after the result has been taken;
// as the memory read is registered, each entry is read in ST_SCAN and examined in ST_WAIT
// aresetn synchronous: valid bits, counts and control cleared, config registers set to their defaults
// depends on wsat_pkg and wsat_ram
module wifi_station_association_table #(
    parameter int unsigned TABLE_ENTRIES = wsat_pkg::TABLE_ENTRIES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // req_type[1:0], fc_byte0[9:2], fc_byte1[17:10], frame_ok[18], tx_mac[66:19],
    // rx_mac[114:67], bss_mac[162:115], bss_present[163], event_time[203:164],
    // query_mac[251:204], zero fill to 256
    input  logic [255:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // tx_changed[0], rx_changed[1], query_hit[2], query_bssid[50:3],
    // client_total[57:51], ap_total[64:58], ibss_total[71:65], table_full[72], fill to 80
    output logic [79:0]  m_tdata
);
    localparam int unsigned AW = $clog2(TABLE_ENTRIES > 1 ? TABLE_ENTRIES : 2);
    localparam int unsigned IW = $clog2(TABLE_ENTRIES + 1);
    localparam int unsigned MW = wsat_pkg::MAC_W;
    localparam int unsigned TW = wsat_pkg::TIME_W;

    // configuration
    logic [31:0] expiry_reg, dupe_reg, aphold_reg, rxhold_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expiry_reg <= wsat_pkg::EXPIRY_RST;
            dupe_reg <= wsat_pkg::DUPE_RST;
            aphold_reg <= wsat_pkg::AP_HOLD_RST;
            rxhold_reg <= wsat_pkg::RX_HOLD_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                wsat_pkg::REG_EXPIRY:  expiry_reg <= cfg_wdata;
                wsat_pkg::REG_DUPE:    dupe_reg <= cfg_wdata;
                wsat_pkg::REG_AP_HOLD: aphold_reg <= cfg_wdata;
                wsat_pkg::REG_RX_HOLD: rxhold_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // captured item
    logic [1:0]    req_reg;
    logic [MW-1:0] ta_reg, ra_reg, bss_reg, q_reg;
    logic [TW-1:0] t_reg;
    logic [7:0]    fc0_reg, fc1_reg;
    logic          ok_reg, bssp_reg;

    // control
    wsat_pkg::state_t state_reg, state_next;
    logic [IW-1:0] idx_reg, idx_next;          // scan position
    logic          phase_reg, phase_next;       // 0 = transmitter update, 1 = receiver
    logic          found_reg, found_next;
    logic [AW-1:0] hit_reg, hit_next;
    logic          free_ok_reg, free_ok_next;
    logic [AW-1:0] free_reg, free_next;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [TABLE_ENTRIES-1:0] valid_next;
    logic [IW-1:0] rd_idx_reg;                  // index of the entry whose read data ram_rd now holds
    logic [IW-1:0] cnt_c_reg, cnt_a_reg, cnt_i_reg, cnt_c_next, cnt_a_next, cnt_i_next;
    logic          txc_reg, txc_next, rxc_reg, rxc_next, full_reg, full_next;
    logic          qhit_reg, qhit_next;
    logic [MW-1:0] qb_reg, qb_next;
    logic          mvalid_reg, mvalid_next;
    logic [79:0]   mdata_reg, mdata_next;

    // memory
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    wsat_pkg::entry_t ram_wd, ram_rd;

    wsat_ram #(.WIDTH(wsat_pkg::ENTRY_W), .DEPTH(TABLE_ENTRIES)) u_ram (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
    );

    // frame filter
    logic pass;
    logic [1:0] dir, trole, rrole;
    assign dir = fc1_reg[1:0];
    assign pass = ok_reg && (fc0_reg[3:2] == 2'b10) && !fc0_reg[6] && !ra_reg[40]
                  && bssp_reg && !ta_reg[40] && (bss_reg != {MW{1'b1}});
    assign trole = {dir == 2'd0, dir == 2'd2};
    assign rrole = {dir == 2'd0, dir == 2'd1};

    logic [MW-1:0] cur_mac;
    logic [1:0]    cur_role;
    assign cur_mac = phase_reg ? ra_reg : ta_reg;
    assign cur_role = phase_reg ? rrole : trole;
    logic [MW-1:0] match_mac;
    assign match_mac = (req_reg == wsat_pkg::REQ_LOOKUP) ? q_reg : cur_mac;

    // time comparisons on the held entry
    logic [TW:0] sum_ap, sum_rx, sum_dup, sum_exp;
    assign sum_ap = {1'b0, ram_rd.upd} + {{(TW-31){1'b0}}, aphold_reg};
    assign sum_rx = {1'b0, ram_rd.txt} + {{(TW-31){1'b0}}, rxhold_reg};
    assign sum_dup = {1'b0, ram_rd.dup} + {{(TW-31){1'b0}}, dupe_reg};
    assign sum_exp = {1'b0, ram_rd.upd} + {{(TW-31){1'b0}}, expiry_reg};
    logic [TW:0] t_ext;
    assign t_ext = {1'b0, t_reg};

    logic rd_valid_entry;
    assign rd_valid_entry = valid_reg[rd_idx_reg[AW-1:0]];

    assign s_tready = (state_reg == wsat_pkg::ST_IDLE) && !mvalid_reg;
    assign m_tvalid = mvalid_reg;
    assign m_tdata = mdata_reg;

    function automatic logic [6:0] sat7(input logic [IW-1:0] v);
        logic [IW+6:0] w;
        w = {{7{1'b0}}, v};
        return (w > (IW+7)'(127)) ? 7'd127 : w[6:0];
    endfunction

    always_comb begin
        state_next = state_reg;
        idx_next = idx_reg;
        phase_next = phase_reg;
        found_next = found_reg;
        hit_next = hit_reg;
        free_ok_next = free_ok_reg;
        free_next = free_reg;
        valid_next = valid_reg;
        cnt_c_next = cnt_c_reg;
        cnt_a_next = cnt_a_reg;
        cnt_i_next = cnt_i_reg;
        txc_next = txc_reg;
        rxc_next = rxc_reg;
        full_next = full_reg;
        qhit_next = qhit_reg;
        qb_next = qb_reg;
        mvalid_next = mvalid_reg;
        mdata_next = mdata_reg;
        ram_we = 1'b0;
        ram_addr = idx_reg[AW-1:0];
        ram_wd = ram_rd;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            wsat_pkg::ST_IDLE: begin
                if (s_tvalid && s_tready) begin
                    txc_next = 1'b0;
                    rxc_next = 1'b0;
                    full_next = 1'b0;
                    qhit_next = 1'b0;
                    qb_next = '0;
                    phase_next = 1'b0;
                    found_next = 1'b0;
                    free_ok_next = 1'b0;
                    idx_next = '0;
                    state_next = wsat_pkg::ST_SCAN;
                end
            end
            wsat_pkg::ST_SCAN: begin
                // one entry per pass: issue read, then examine
                if ((req_reg == wsat_pkg::REQ_FRAME && !pass) ||
                    (req_reg != wsat_pkg::REQ_FRAME && req_reg != wsat_pkg::REQ_SWEEP &&
                     req_reg != wsat_pkg::REQ_LOOKUP)) begin
                    state_next = wsat_pkg::ST_OUT;
                end else if (idx_reg == IW'(TABLE_ENTRIES)) begin
                    state_next = (req_reg == wsat_pkg::REQ_FRAME) ?
                                 wsat_pkg::ST_APPLY : wsat_pkg::ST_OUT;
                    ram_addr = found_next ? hit_next : hit_reg;
                    if (req_reg == wsat_pkg::REQ_FRAME) begin
                        ram_addr = found_reg ? hit_reg : free_reg;
                    end
                end else begin
                    ram_addr = idx_reg[AW-1:0];
                    state_next = wsat_pkg::ST_WAIT;
                end
            end
            wsat_pkg::ST_WAIT: begin
                ram_addr = rd_idx_reg[AW-1:0];
                if (rd_valid_entry) begin
                    if (req_reg == wsat_pkg::REQ_SWEEP) begin
                        if (sum_exp <= t_ext) begin
                            valid_next[rd_idx_reg[AW-1:0]] = 1'b0;
                        end
                    end else if (!found_reg && ram_rd.key == match_mac) begin
                        found_next = 1'b1;
                        hit_next = rd_idx_reg[AW-1:0];
                        if (req_reg == wsat_pkg::REQ_LOOKUP) begin
                            qhit_next = 1'b1;
                            qb_next = ram_rd.bssid;
                        end
                    end
                end else if (!free_ok_reg) begin
                    free_ok_next = 1'b1;
                    free_next = rd_idx_reg[AW-1:0];
                end
                idx_next = idx_reg + IW'(1);
                state_next = wsat_pkg::ST_SCAN;
            end
            wsat_pkg::ST_APPLY: begin
                // ram_rd now holds the matched entry, or the free slot when there is no match
                ram_addr = found_reg ? hit_reg : free_reg;
                if (!found_reg) begin
                    if (free_ok_reg) begin
                        ram_we = 1'b1;
                        ram_wd.key = cur_mac;
                        ram_wd.bssid = bss_reg;
                        ram_wd.role = cur_role;
                        ram_wd.upd = t_reg;
                        ram_wd.dup = t_reg;
                        ram_wd.txt = phase_reg ? '0 : t_reg;
                        valid_next[free_reg] = 1'b1;
                        if (phase_reg) rxc_next = 1'b1; else txc_next = 1'b1;
                    end else begin
                        full_next = 1'b1;
                    end
                end else if (ram_rd.bssid != bss_reg) begin
                    if (!((ram_rd.role[wsat_pkg::ROLE_AP_BIT] && t_ext <= sum_ap) ||
                          (phase_reg && t_ext < sum_rx))) begin
                        ram_we = 1'b1;
                        ram_wd.bssid = bss_reg;
                        ram_wd.role = cur_role;
                        ram_wd.upd = t_reg;
                        ram_wd.dup = t_reg;
                        if (!phase_reg) ram_wd.txt = t_reg;
                        if (phase_reg) rxc_next = 1'b1; else txc_next = 1'b1;
                    end
                end else begin
                    ram_we = 1'b1;
                    ram_wd.upd = t_reg;
                    if (sum_dup <= t_ext) begin
                        ram_wd.dup = t_reg;
                        if (phase_reg) rxc_next = 1'b1; else txc_next = 1'b1;
                    end
                end
                if (!phase_reg) begin
                    phase_next = 1'b1;
                    found_next = 1'b0;
                    free_ok_next = 1'b0;
                    idx_next = '0;
                    state_next = wsat_pkg::ST_SCAN;
                end else begin
                    state_next = wsat_pkg::ST_OUT;
                end
            end
            wsat_pkg::ST_OUT: begin
                state_next = wsat_pkg::ST_COUNT;
                idx_next = '0;
                cnt_c_next = '0;
                cnt_a_next = '0;
                cnt_i_next = '0;
            end
            wsat_pkg::ST_COUNT: begin
                // recount from the entry memory: each entry's role is seen in the cycle after its read is issued
                ram_addr = idx_reg[AW-1:0];
                if (idx_reg != '0 && rd_valid_entry) begin
                    if (ram_rd.role[wsat_pkg::ROLE_IBSS_BIT])
                        cnt_i_next = cnt_i_reg + IW'(1);
                    else if (ram_rd.role[wsat_pkg::ROLE_AP_BIT])
                        cnt_a_next = cnt_a_reg + IW'(1);
                    else
                        cnt_c_next = cnt_c_reg + IW'(1);
                end
                if (idx_reg == IW'(TABLE_ENTRIES)) begin
                    // output slot is free here, input waits for it to drain
                    mvalid_next = 1'b1;
                    mdata_next = {7'd0, full_reg, sat7(cnt_i_next), sat7(cnt_a_next),
                                  sat7(cnt_c_next), qb_reg, qhit_reg, rxc_reg, txc_reg};
                    state_next = wsat_pkg::ST_IDLE;
                end else begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            default: state_next = wsat_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= wsat_pkg::ST_IDLE;
            valid_reg <= '0;
            mvalid_reg <= 1'b0;
            cnt_c_reg <= '0;
            cnt_a_reg <= '0;
            cnt_i_reg <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            mvalid_reg <= mvalid_next;
            cnt_c_reg <= cnt_c_next;
            cnt_a_reg <= cnt_a_next;
            cnt_i_reg <= cnt_i_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        phase_reg <= phase_next;
        found_reg <= found_next;
        hit_reg <= hit_next;
        free_ok_reg <= free_ok_next;
        free_reg <= free_next;
        txc_reg <= txc_next;
        rxc_reg <= rxc_next;
        full_reg <= full_next;
        qhit_reg <= qhit_next;
        qb_reg <= qb_next;
        mdata_reg <= mdata_next;
        rd_idx_reg <= idx_reg;
        if (s_tvalid && s_tready) begin
            req_reg <= s_tdata[1:0];
            fc0_reg <= s_tdata[9:2];
            fc1_reg <= s_tdata[17:10];
            ok_reg <= s_tdata[18];
            ta_reg <= s_tdata[66:19];
            ra_reg <= s_tdata[114:67];
            bss_reg <= s_tdata[162:115];
            bssp_reg <= s_tdata[163];
            t_reg <= s_tdata[203:164];
            q_reg <= s_tdata[251:204];
        end
    end
endmodule

/* sv/wsat_ram.sv */
// wsat_ram: generic single-port synchronous ram, registered read
// no dependencies
module wsat_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

/* tb/wifi_station_association_table_tb.sv */
// testbench for the station association table: directed and random words,
// a self-contained table predictor and an in-order scoreboard
// depends on wsat_pkg and wifi_station_association_table
module wifi_station_association_table_tb;

    localparam int unsigned MAC_W  = wsat_pkg::MAC_W;
    localparam int unsigned TIME_W = wsat_pkg::TIME_W;
    localparam int unsigned CNT_W  = wsat_pkg::CNT_W;
    localparam int unsigned ROLE_W = wsat_pkg::ROLE_W;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;
    localparam logic [7:0] FC_TYPE_MASK = 8'h0c;
    localparam logic [7:0] FC_TYPE_DATA = 8'h08;
    localparam logic [7:0] FC_NODATA    = 8'h40;
    localparam logic [1:0] DIR_NODS     = 2'd0;
    localparam logic [1:0] DIR_TODS     = 2'd1;
    localparam logic [1:0] DIR_FROMDS   = 2'd2;
    localparam logic [1:0] DIR_WDS      = 2'd3;
    localparam logic [MAC_W-1:0] GROUP_BIT = 48'h0100_0000_0000;
    localparam logic [MAC_W-1:0] MAC_ONES  = '1;
    localparam logic [TIME_W-1:0] TIME_MAX = '1;
    localparam int NENT = wsat_pkg::TABLE_ENTRIES_DEF;
    localparam int STALL_LIMIT = 6000;   // cycles with no word moving
    localparam int DRAIN_CYCLES = 400;   // beyond the longest frame latency

    typedef struct {
        logic [1:0]        req;
        logic [7:0]        fc0;
        logic [7:0]        fc1;
        logic              ok;
        logic [MAC_W-1:0]  ta;
        logic [MAC_W-1:0]  ra;
        logic [MAC_W-1:0]  bss;
        logic              bss_here;
        logic [TIME_W-1:0] t;
        logic [MAC_W-1:0]  q;
    } frame_req_t;

    typedef struct packed {
        logic              txc;
        logic              rxc;
        logic              hit;
        logic [MAC_W-1:0]  qbss;
        logic [CNT_W-1:0]  clients;
        logic [CNT_W-1:0]  aps;
        logic [CNT_W-1:0]  ibss;
        logic              full;
    } table_resp_t;

    logic         aclk;
    logic         aresetn;
    logic         cfg_we;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    // req_type, fc_byte0, fc_byte1, frame_ok, tx_mac, rx_mac, bss_mac,
    // bss_present, event_time, query_mac, zero fill
    logic [255:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    // tx_changed, rx_changed, query_hit, query_bssid, client_total,
    // ap_total, ibss_total, table_full, zero fill
    logic [79:0]  m_tdata;

    wifi_station_association_table i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        aclk = 1'b1; #5;
        aclk = 1'b0; #5;
    end

    // predictor copy of the table and registers
    logic [31:0]       p_expiry, p_dupe, p_ap_hold, p_rx_hold;
    logic              p_valid [NENT];
    logic [MAC_W-1:0]  p_key   [NENT];
    logic [MAC_W-1:0]  p_bssid [NENT];
    logic [ROLE_W-1:0] p_role  [NENT];
    logic [TIME_W-1:0] p_upd   [NENT];
    logic [TIME_W-1:0] p_dup   [NENT];
    logic [TIME_W-1:0] p_txt   [NENT];
    logic              p_full;

    table_resp_t pending_resp [$];
    int  fail_count = 0;
    int  quiet_cycles = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    logic [TIME_W-1:0] now_ms;
    logic [MAC_W-1:0]  sta_pool [16];
    logic [MAC_W-1:0]  bss_pool [4];

    function automatic int find_station(logic [MAC_W-1:0] mac);
        for (int i = 0; i < NENT; i++)
            if (p_valid[i] && p_key[i] == mac) return i;
        return -1;
    endfunction

    // insert, reassign or refresh one station; returns the changed flag
    function automatic logic touch_station(logic [MAC_W-1:0] mac, logic [MAC_W-1:0] bss,
                                           logic [TIME_W-1:0] t, logic [ROLE_W-1:0] role,
                                           logic as_tx);
        int s;
        s = find_station(mac);
        if (s < 0) begin
            for (int i = 0; i < NENT; i++) begin
                if (!p_valid[i]) begin
                    p_valid[i] = 1'b1;
                    p_key[i]   = mac;
                    p_bssid[i] = bss;
                    p_role[i]  = role;
                    p_upd[i]   = t;
                    p_dup[i]   = t;
                    p_txt[i]   = as_tx ? t : '0;
                    return 1'b1;
                end
            end
            p_full = 1'b1;
            return 1'b0;
        end
        if (p_bssid[s] != bss) begin
            // ap hold-off: sums are 41 bits so nothing wraps
            if (p_role[s][wsat_pkg::ROLE_AP_BIT] &&
                {1'b0, t} <= {1'b0, p_upd[s]} + 41'(p_ap_hold))
                return 1'b0;
            // receiver may not reassign soon after a transmitter update
            if (!as_tx && {1'b0, t} < {1'b0, p_txt[s]} + 41'(p_rx_hold))
                return 1'b0;
            p_bssid[s] = bss;
            p_role[s]  = role;
            p_upd[s]   = t;
            p_dup[s]   = t;
            if (as_tx) p_txt[s] = t;
            return 1'b1;
        end
        p_upd[s] = t;
        if ({1'b0, p_dup[s]} + 41'(p_dupe) <= {1'b0, t}) begin
            p_dup[s] = t;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic table_resp_t predict_table(frame_req_t r);
        table_resp_t o;
        logic [ROLE_W-1:0] trole, rrole;
        logic [1:0] dir;
        int s;
        o = '0;
        p_full = 1'b0;
        dir = r.fc1[1:0];
        if (r.req == wsat_pkg::REQ_FRAME) begin
            if (r.ok && (r.fc0 & FC_TYPE_MASK) == FC_TYPE_DATA && !(r.fc0 & FC_NODATA) &&
                !(r.ra & GROUP_BIT) && r.bss_here && !(r.ta & GROUP_BIT) &&
                r.bss != MAC_ONES) begin
                trole = '0;
                rrole = '0;
                trole[wsat_pkg::ROLE_AP_BIT]   = (dir == DIR_FROMDS);
                rrole[wsat_pkg::ROLE_AP_BIT]   = (dir == DIR_TODS);
                trole[wsat_pkg::ROLE_IBSS_BIT] = (dir == DIR_NODS);
                rrole[wsat_pkg::ROLE_IBSS_BIT] = (dir == DIR_NODS);
                o.txc = touch_station(r.ta, r.bss, r.t, trole, 1'b1);
                o.rxc = touch_station(r.ra, r.bss, r.t, rrole, 1'b0);
            end
        end else if (r.req == wsat_pkg::REQ_SWEEP) begin
            for (int i = 0; i < NENT; i++)
                if (p_valid[i] && {1'b0, p_upd[i]} + 41'(p_expiry) <= {1'b0, r.t})
                    p_valid[i] = 1'b0;
        end else if (r.req == wsat_pkg::REQ_LOOKUP) begin
            s = find_station(r.q);
            if (s >= 0) begin
                o.hit  = 1'b1;
                o.qbss = p_bssid[s];
            end
        end
        for (int i = 0; i < NENT; i++) begin
            if (!p_valid[i]) continue;
            if (p_role[i][wsat_pkg::ROLE_IBSS_BIT]) o.ibss++;
            else if (p_role[i][wsat_pkg::ROLE_AP_BIT]) o.aps++;
            else o.clients++;
        end
        o.full = p_full;
        return o;
    endfunction

    // one word to the block; the expectation is booked when it is taken
    task automatic send_req(frame_req_t r);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, r.q, r.t, r.bss_here, r.bss, r.ra, r.ta, r.ok,
                     r.fc1, r.fc0, r.req};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_resp.insert(pending_resp.size(), predict_table(r));
    endtask

    // stop sending until every expected word is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_resp.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        unique case (idx)
            wsat_pkg::REG_EXPIRY:  p_expiry  = val;
            wsat_pkg::REG_DUPE:    p_dupe    = val;
            wsat_pkg::REG_AP_HOLD: p_ap_hold = val;
            wsat_pkg::REG_RX_HOLD: p_rx_hold = val;
        endcase
    endtask

    task automatic set_timers(logic [31:0] ex, logic [31:0] du, logic [31:0] ap,
                              logic [31:0] rx);
        drain_results();
        write_reg(wsat_pkg::REG_EXPIRY, ex);
        write_reg(wsat_pkg::REG_DUPE, du);
        write_reg(wsat_pkg::REG_AP_HOLD, ap);
        write_reg(wsat_pkg::REG_RX_HOLD, rx);
    endtask

    function automatic logic [MAC_W-1:0] rand_mac();
        return {16'($urandom), 32'($urandom)};
    endfunction

    function automatic frame_req_t data_frame(logic [MAC_W-1:0] ta, logic [MAC_W-1:0] ra,
                                              logic [MAC_W-1:0] bss, logic [1:0] dir,
                                              logic [TIME_W-1:0] t);
        frame_req_t r;
        r.req = wsat_pkg::REQ_FRAME;
        r.fc0 = FC_TYPE_DATA;
        r.fc1 = {6'h0, dir};
        r.ok = 1'b1;
        r.ta = ta;
        r.ra = ra;
        r.bss = bss;
        r.bss_here = 1'b1;
        r.t = t;
        r.q = '0;
        return r;
    endfunction

    function automatic frame_req_t ctl_req(logic [1:0] req, logic [TIME_W-1:0] t,
                                           logic [MAC_W-1:0] q);
        frame_req_t r;
        r = data_frame('0, '0, '0, DIR_NODS, t);
        r.req = req;
        r.q = q;
        return r;
    endfunction

    // filter: each rejection reason alone, then one frame that passes
    task automatic test_filter();
        frame_req_t r;
        for (int k = 0; k < 7; k++) begin
            r = data_frame(48'h0200_0000_0011, 48'h0200_0000_0022, 48'h0200_0000_00b0,
                           DIR_TODS, 40'd100);
            case (k)
                0: r.ok = 1'b0;
                1: r.fc0 = 8'h04;                      // control frame type
                2: r.fc0 = FC_TYPE_DATA | FC_NODATA;   // null data subtype
                3: r.ra = r.ra | GROUP_BIT;            // multicast receiver
                4: r.ta = r.ta | GROUP_BIT;            // multicast transmitter
                5: r.bss_here = 1'b0;
                default: r.bss = MAC_ONES;             // broadcast bssid
            endcase
            send_req(r);
        end
        r = data_frame(48'h0200_0000_0011, 48'h0200_0000_0022, 48'h0200_0000_00b0,
                       DIR_TODS, 40'd100);
        r.fc0 = 8'hbb;                                 // data type, other bits set
        send_req(r);
    endtask

    // every direction, refresh, reassignment, holds, lookup, sweep, unused type
    task automatic test_roles();
        send_req(data_frame(48'h0a00_0000_0001, 48'h0a00_0000_0002, 48'h0a00_0000_0003,
                            DIR_NODS, 40'd200));
        send_req(data_frame(48'h0a00_0000_0004, 48'h0a00_0000_0005, 48'h0a00_0000_0006,
                            DIR_FROMDS, 40'd200));
        send_req(data_frame(48'hfeff_ffff_fffe, '0, 48'h0a00_0000_0006,
                            DIR_WDS, TIME_MAX));             // extreme addresses and time
        send_req(data_frame(48'h0a00_0000_0004, 48'h0a00_0000_0002, 48'h0a00_0000_0007,
                            DIR_TODS, 40'd250));             // ap hold, rx hold
        send_req(data_frame(48'h0a00_0000_0004, 48'h0a00_0000_0002, 48'h0a00_0000_0007,
                            DIR_TODS, 40'd70000));           // reassign after holds
        send_req(data_frame(48'h0a00_0000_0004, 48'h0a00_0000_0002, 48'h0a00_0000_0007,
                            DIR_TODS, 40'd70001));           // refresh inside dupe window
        send_req(ctl_req(wsat_pkg::REQ_LOOKUP, '0, 48'h0a00_0000_0004));
        send_req(ctl_req(wsat_pkg::REQ_LOOKUP, '0, 48'h0a00_0000_0099));
        send_req(ctl_req(REQ_UNUSED, TIME_MAX, MAC_ONES));
        send_req(ctl_req(wsat_pkg::REQ_SWEEP, 40'd300300, '0));
        send_req(ctl_req(wsat_pkg::REQ_LOOKUP, '0, 48'hfeff_ffff_fffe));
        send_req(ctl_req(wsat_pkg::REQ_SWEEP, TIME_MAX, '0));
    endtask

    // fill past capacity so new stations are dropped, then sweep out all entries updated at or before 1000
    task automatic test_table_full();
        for (int k = 0; k < NENT / 2 + 2; k++)
            send_req(data_frame({32'h0c00_0000, 16'(2 * k)}, {32'h0c00_0000, 16'(2 * k + 1)},
                                48'h0c00_0000_ffff, DIR_TODS, 40'd1000));
        set_timers(32'd0, 32'd0, 32'd0, 32'd0);
        send_req(ctl_req(wsat_pkg::REQ_SWEEP, 40'd1000, '0));
    endtask

    function automatic frame_req_t rand_req();
        frame_req_t r;
        int pick;
        pick = $urandom_range(99);
        if ($urandom_range(9) == 0) now_ms = now_ms + 40'($urandom_range(2000));
        else now_ms = now_ms + 40'($urandom_range(60));
        r = data_frame(sta_pool[$urandom_range(15)], sta_pool[$urandom_range(15)],
                       bss_pool[$urandom_range(3)], 2'($urandom_range(2)), now_ms);
        r.fc0 = (8'($urandom) & ~(FC_TYPE_MASK | FC_NODATA)) | FC_TYPE_DATA;
        r.fc1 = {6'($urandom), r.fc1[1:0]};
        if (pick < 10) begin
            r.req = wsat_pkg::REQ_LOOKUP;
            r.q = ($urandom_range(3) == 0) ? rand_mac() : sta_pool[$urandom_range(15)];
        end else if (pick < 15) begin
            r.req = wsat_pkg::REQ_SWEEP;
        end else if (pick < 30) begin
            // noise: every field random
            r = '{req: 2'($urandom), fc0: 8'($urandom), fc1: 8'($urandom),
                  ok: 1'($urandom), ta: rand_mac(), ra: rand_mac(), bss: rand_mac(),
                  bss_here: 1'($urandom), t: {8'($urandom), 32'($urandom)},
                  q: rand_mac()};
        end
        return r;
    endfunction

    task automatic test_random(int count);
        for (int k = 0; k < count; k++) begin
            send_req(rand_req());
            if (k == count / 2) drain_results();
        end
    endtask

    // scoreboard
    always @(posedge aclk) begin
        table_resp_t exp_r, got;
        if (aresetn && m_tvalid && m_tready) begin
            got.txc     = m_tdata[0];
            got.rxc     = m_tdata[1];
            got.hit     = m_tdata[2];
            got.qbss    = m_tdata[50:3];
            got.clients = m_tdata[57:51];
            got.aps     = m_tdata[64:58];
            got.ibss    = m_tdata[71:65];
            got.full    = m_tdata[72];
            if (pending_resp.size() == 0) begin
                $display("%0t: unexpected word %h", $time, m_tdata);
                fail_count++;
            end else begin
                exp_r = pending_resp.pop_front();
                if (got != exp_r) begin
                    $display("%0t: mismatch expected tx %b rx %b hit %b bss %h c %0d a %0d i %0d f %b",
                             $time, exp_r.txc, exp_r.rxc, exp_r.hit, exp_r.qbss,
                             exp_r.clients, exp_r.aps, exp_r.ibss, exp_r.full);
                    $display("%0t:   actual   tx %b rx %b hit %b bss %h c %0d a %0d i %0d f %b",
                             $time, got.txc, got.rxc, got.hit, got.qbss,
                             got.clients, got.aps, got.ibss, got.full);
                    fail_count++;
                end
            end
        end
    end

    // receiver stalls and watchdog
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        p_expiry = wsat_pkg::EXPIRY_RST;
        p_dupe = wsat_pkg::DUPE_RST;
        p_ap_hold = wsat_pkg::AP_HOLD_RST;
        p_rx_hold = wsat_pkg::RX_HOLD_RST;
        p_full = 1'b0;
        now_ms = '0;
        for (int i = 0; i < NENT; i++) p_valid[i] = 1'b0;
        for (int i = 0; i < 16; i++) sta_pool[i] = rand_mac() & ~GROUP_BIT;
        for (int i = 0; i < 4; i++) bss_pool[i] = rand_mac();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset values of the timers (zeroed before the final sweep of the full-table test)
        send_idle_pct = 10;
        recv_idle_pct = 62;
        test_filter();
        test_roles();
        test_table_full();

        // small random timers so holds and refresh windows are crossed often
        set_timers(32'($urandom_range(3000)), 32'($urandom_range(150)),
                   32'($urandom_range(150)), 32'($urandom_range(150)));
        test_random(350);
        send_idle_pct = 62;
        recv_idle_pct = 10;
        set_timers(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        test_random(150);
        set_timers(32'($urandom_range(500)), 32'd0, 32'd0, 32'($urandom_range(100)));
        test_random(200);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_timers(32'($urandom_range(3000)), 32'($urandom_range(100)),
                   32'($urandom_range(100)), 32'($urandom_range(100)));
        test_random(300);

        drain_results();
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
